### design/cshr_pkg.sv
// cshr_pkg: shared types and constants for the coalescing sample history ring
// used by cshr_front, cshr_back and the top level; no dependencies

package cshr_pkg;

    // function codes of an input word
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // temperatures that a query never reports: 0.0 degC and -127.0 degC
    localparam logic signed [11:0] TEMP_ZERO = 12'sh000;
    localparam logic signed [11:0] TEMP_M127 = 12'sh810;

    // merge window after reset, in seconds
    localparam logic [15:0] MERGE_WINDOW_RESET = 16'd300;

    // one stored slot
    typedef struct packed {
        logic [31:0]        time_s;
        logic signed [11:0] temp;
        logic [63:0]        sensor;
    } entry_t;

    // classified command from front to back
    typedef struct packed {
        logic               is_query;
        logic [31:0]        time_a;   // sample time, or range start
        logic [31:0]        time_b;   // range end
        logic signed [11:0] temp;
        logic [63:0]        sensor;
    } cmd_t;

endpackage

### design/cshr_ram.sv
// cshr_ram: generic single write port, single read port RAM with registered read
// no dependencies

module cshr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/cshr_queue.sv
// cshr_queue: small first-word fall-through queue between front and back
// no dependencies

module cshr_queue #(
    parameter int WIDTH = 8,
    parameter int QDEPTH = 4,
    parameter int IDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1,
    parameter int CNT_W = $clog2(QDEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] store_reg [QDEPTH];
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_idx_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and count update
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (push) begin
            wr_idx_next = (wr_idx_reg == IDX_W'(QDEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (pop) begin
            rd_idx_next = (rd_idx_reg == IDX_W'(QDEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_idx_reg] <= push_data;
        end
    end

endmodule

### design/cshr_front.sv
// cshr_front: accepts input words, decides merge or append, tracks ring pointers
// depends on cshr_pkg

module cshr_front #(
    parameter int DEPTH = 64,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [31:0]         s_sample_time,
    input  logic signed [11:0]  s_sample_temp,
    input  logic [63:0]         s_sensor_id,
    input  logic [31:0]         s_range_start,
    input  logic [31:0]         s_range_end,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cshr_pkg::cmd_t      cmd,
    output logic [IDX_W-1:0]    cmd_addr,
    output logic [CNT_W-1:0]    cmd_count
);

    import cshr_pkg::*;

    logic [IDX_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      last_time_reg, last_time_next;
    logic [63:0]      last_sensor_reg, last_sensor_next;
    logic [15:0]      merge_window_reg;
    logic             accept, is_query, merge;
    logic [31:0]      age;
    logic [IDX_W-1:0] newest, wp_inc, start;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;
    assign is_query  = (s_func == FUNC_QUERY);

    // merge decision against the newest slot
    assign age   = s_sample_time - last_time_reg;
    assign merge = (s_sensor_id != '0) && (s_sensor_id == last_sensor_reg) &&
                   (fill_reg != '0) && (age < {16'b0, merge_window_reg});

    assign newest = (wp_reg == '0) ? IDX_W'(DEPTH - 1) : wp_reg - 1'b1;
    assign wp_inc = (wp_reg == IDX_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    // until the ring wraps the oldest slot is slot zero
    assign start  = (fill_reg == CNT_W'(DEPTH)) ? wp_reg : '0;

    // command word
    always_comb begin
        cmd.is_query = is_query;
        cmd.time_a   = is_query ? s_range_start : s_sample_time;
        cmd.time_b   = s_range_end;
        cmd.temp     = s_sample_temp;
        cmd.sensor   = s_sensor_id;
        cmd_count    = fill_reg;
        if (is_query) begin
            cmd_addr = start;
        end else if (merge) begin
            cmd_addr = newest;
        end else begin
            cmd_addr = wp_reg;
        end
    end

    // ring bookkeeping on append
    always_comb begin
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        last_time_next   = last_time_reg;
        last_sensor_next = last_sensor_reg;
        if (accept && !is_query && !merge) begin
            wp_next          = wp_inc;
            fill_next        = (fill_reg == CNT_W'(DEPTH)) ? fill_reg : fill_reg + 1'b1;
            last_time_next   = s_sample_time;
            last_sensor_next = s_sensor_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg           <= '0;
            fill_reg         <= '0;
            last_time_reg    <= '0;
            last_sensor_reg  <= '0;
            merge_window_reg <= MERGE_WINDOW_RESET;
        end else begin
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            last_time_reg   <= last_time_next;
            last_sensor_reg <= last_sensor_next;
            if (cfg_wr_en) begin
                merge_window_reg <= cfg_wr_data;
            end
        end
    end

    // fill count never passes the depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // before the first wrap the write pointer equals the fill count
    a_wp_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != CNT_W'(DEPTH)) |-> (wp_reg == fill_reg[IDX_W-1:0]))
        else $error("write pointer out of step with fill count");

    // an empty ring never merges
    a_no_merge_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> !merge)
        else $error("merge into empty ring");

endmodule

### design/cshr_back.sv
// cshr_back: carries out slot writes and query walks over the slot RAM
// depends on cshr_pkg and cshr_ram

module cshr_back #(
    parameter int DEPTH = 64,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cshr_pkg::cmd_t      cmd,
    input  logic [IDX_W-1:0]    cmd_addr,
    input  logic [CNT_W-1:0]    cmd_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [31:0]         m_entry_time,
    output logic signed [11:0]  m_entry_temp,
    output logic [63:0]         m_entry_sensor,
    output logic                m_last
);

    import cshr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [31:0]      lo_reg, lo_next;
    logic [31:0]      hi_reg, hi_next;
    logic             pend_valid_reg, pend_valid_next;
    entry_t           pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    entry_t           m_entry_reg, m_entry_next;
    logic             m_last_reg, m_last_next;

    logic             ram_we, ram_re;
    entry_t           wr_entry, rd_entry;
    logic             hit, out_free;

    assign wr_entry.time_s = cmd.time_a;
    assign wr_entry.temp   = cmd.temp;
    assign wr_entry.sensor = cmd.sensor;

    cshr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cmd_addr),
        .wr_data (wr_entry),
        .rd_en   (ram_re),
        .rd_addr (ptr_reg),
        .rd_data (rd_entry)
    );

    // range and temperature filter on the slot just read
    assign hit = (rd_entry.time_s >= lo_reg) && (rd_entry.time_s <= hi_reg) &&
                 (rd_entry.temp != TEMP_ZERO) && (rd_entry.temp != TEMP_M127);

    assign out_free = !m_valid_reg || m_ready;

    // sequencer: one match is held back so the final one can carry last
    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_entry_next    = m_entry_reg;
        m_last_next     = m_last_reg;
        cmd_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (cmd.is_query) begin
                        lo_next         = cmd.time_a;
                        hi_next         = cmd.time_b;
                        ptr_next        = cmd_addr;
                        rem_next        = cmd_count;
                        pend_valid_next = 1'b0;
                        state_next      = (cmd_count == '0) ? ST_FLUSH : ST_READ;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit && pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_found_next = 1'b1;
                        m_entry_next = pend_reg;
                        m_last_next  = 1'b0;
                    end
                    if (hit) begin
                        pend_next       = rd_entry;
                        pend_valid_next = 1'b1;
                    end
                    ptr_next   = (ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    state_next = (rem_reg == CNT_W'(1)) ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_found_next    = pend_valid_reg;
                    m_entry_next    = pend_valid_reg ? pend_reg : '0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            ptr_reg        <= ptr_next;
            rem_reg        <= rem_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            pend_reg       <= pend_next;
            m_found_reg    <= m_found_next;
            m_entry_reg    <= m_entry_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_entry_time   = m_entry_reg.time_s;
    assign m_entry_temp   = m_entry_reg.temp;
    assign m_entry_sensor = m_entry_reg.sensor;
    assign m_last         = m_last_reg;

    // an empty result always closes its query
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_last_reg)
        else $error("empty result without last");

    // a walk never checks a slot beyond the count
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (rem_reg != '0))
        else $error("walk ran past the fill count");

    // no new command is taken while a query is in progress
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd_ready)
        else $error("command taken during a walk");

endmodule

### design/coalescing_sample_history_ring.sv
// coalescing_sample_history_ring: top level, front, command queue and back
// depends on cshr_pkg, cshr_front, cshr_queue and cshr_back

// A ring of DEPTH timestamped temperature slots. An add word (func 0) either
// overwrites the newest slot, when it comes from the same nonzero sensor as
// the last appended slot within merge_window seconds of that slot's creation,
// or appends a slot, overwriting the oldest once the ring is full. An add word
// gives no result. A query word (func 1) walks the stored slots from oldest to
// newest and returns every slot whose time is in [range_start, range_end] and
// whose temperature is neither 0 nor -127 degC, with last set on the final one;
// with no match it returns one word with found = 0 and last = 1. A query reads
// the stored slots one at a time through the registered read of the slot RAM,
// checks each slot read, and can wait while the result channel stalls. Input
// words are taken into a four-word queue while the back is busy, so the input
// stalls only once that queue is full. merge_window may be written only while
// the block is idle.

module coalescing_sample_history_ring #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [31:0]         s_sample_time,
    input  logic signed [11:0]  s_sample_temp,
    input  logic [63:0]         s_sensor_id,
    input  logic [31:0]         s_range_start,
    input  logic [31:0]         s_range_end,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [31:0]         m_entry_time,
    output logic signed [11:0]  m_entry_temp,
    output logic [63:0]         m_entry_sensor,
    output logic                m_last,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    import cshr_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int Q_W    = $bits(cmd_t) + IDX_W + CNT_W;
    localparam int QDEPTH = 4;

    logic             f_valid, f_ready;
    cmd_t             f_cmd, b_cmd;
    logic [IDX_W-1:0] f_addr, b_addr;
    logic [CNT_W-1:0] f_count, b_count;
    logic             b_valid, b_ready;
    logic [Q_W-1:0]   q_push_word, q_pop_word;

    // front: accept and classify
    cshr_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_sample_time (s_sample_time),
        .s_sample_temp (s_sample_temp),
        .s_sensor_id   (s_sensor_id),
        .s_range_start (s_range_start),
        .s_range_end   (s_range_end),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd),
        .cmd_addr      (f_addr),
        .cmd_count     (f_count)
    );

    // command queue
    assign q_push_word = {f_cmd, f_addr, f_count};

    cshr_queue #(
        .WIDTH  (Q_W),
        .QDEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_push_word),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_pop_word)
    );

    assign {b_cmd, b_addr, b_count} = q_pop_word;

    // back: slot writes and query walks
    cshr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (b_valid),
        .cmd_ready      (b_ready),
        .cmd            (b_cmd),
        .cmd_addr       (b_addr),
        .cmd_count      (b_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_entry_time   (m_entry_time),
        .m_entry_temp   (m_entry_temp),
        .m_entry_sensor (m_entry_sensor),
        .m_last         (m_last)
    );

endmodule
